// File: hw/rtl/stfr_pkg.sv
// ----------------------------------------------------------------------------
// stfr_pkg
// shared constants and types for the stuffed frame length router
// ----------------------------------------------------------------------------
package stfr_pkg;

   localparam logic [7:0] FLAG_START   = 8'h7E;
   localparam logic [7:0] FLAG_ESCAPE  = 8'h7D;
   localparam logic [7:0] ESC_OF_7D    = 8'h5D;
   localparam logic [7:0] ESC_OF_7E    = 8'h5E;
   localparam logic [7:0] TOTAL_EXTRA  = 8'd5;
   localparam logic [8:0] RAW_MAX      = 9'd511;
   localparam logic [7:0] THRESH_RESET = 8'd127;

   // tuser bit positions of the response channel
   localparam int USER_RESTART = 0;
   localparam int USER_VALID   = 1;
   localparam int USER_INJECT  = 2;
   localparam int USER_WIDTH   = 3;
   localparam int DATA_WIDTH   = 48;

   typedef struct packed {
      logic [7:0] raw_byte;
      logic       raw_restart;
      logic       frame_byte_valid;
      logic [7:0] frame_byte;
      logic [7:0] frame_index;
      logic       frame_done;
      logic [7:0] frame_length;
      logic       route_inject;
      logic [8:0] raw_length;
   } stfr_result_type;

endpackage

// File: hw/rtl/stuffed_frame_length_router.sv
// ----------------------------------------------------------------------------
// stuffed_frame_length_router
// byte-stuffed frame deframer with length-based completion and routing
// ----------------------------------------------------------------------------
//  channel | dir | handshake            | payload
//  req     | in  | req_tvalid/tready    | tdata[7:0] rx_byte
//  rsp     | out | rsp_tvalid/tready    | tdata, tuser, tlast (frame_done)
//  csr     | in  | csr_valid/csr_ready  | csr_data[7:0] inject_threshold
//
//  one request per cycle sustained while rsp_tready stays high; each request
//  passes through the input register, then the response register
//  the frame state updates as a request moves from the input register into
//  the response register, so every byte sees the state left by its predecessor
//  reset is synchronous and clears all frame state, threshold returns to 127
//  a stalled response holds the input register; req_tready drops only when
//  both registers are full and rsp_tready is low
// ----------------------------------------------------------------------------
module stuffed_frame_length_router
   import stfr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // request: [7:0] rx_byte
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,
   // response: [7:0] raw_byte, [15:8] frame_byte, [23:16] frame_index,
   // [31:24] frame_length, [40:32] raw_length, [47:41] zero
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [DATA_WIDTH-1:0] rsp_tdata,
   // response: [0] raw_restart, [1] frame_byte_valid, [2] route_inject
   output logic [USER_WIDTH-1:0] rsp_tuser,
   output logic                  rsp_tlast,
   // threshold write
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [7:0]            csr_data
);

   logic            in_valid_ff;
   logic [7:0]      in_byte_ff;
   logic [7:0]      threshold_ff;
   logic            advance;
   logic            out_valid;
   stfr_result_type result;
   stfr_result_type result_q;

   // threshold register, always writable
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESH_RESET;
      end else if (csr_valid) begin
         threshold_ff <= csr_data;
      end
   end

   // move a byte into the response register when that register is free or is taken
   assign advance    = in_valid_ff & (~out_valid | rsp_tready);
   assign req_tready = ~in_valid_ff | advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
      end
   end

   stfr_tracker u_tracker (
      .clock            (clock),
      .reset            (reset),
      .advance          (advance),
      .rx_byte          (in_byte_ff),
      .inject_threshold (threshold_ff),
      .result           (result)
   );

   stfr_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (advance),
      .result_in  (result),
      .take       (rsp_tready),
      .valid      (out_valid),
      .result_out (result_q)
   );

   // pack the response
   assign rsp_tvalid = out_valid;
   assign rsp_tdata  = {7'd0, result_q.raw_length, result_q.frame_length,
                        result_q.frame_index, result_q.frame_byte, result_q.raw_byte};
   assign rsp_tuser  = {result_q.route_inject, result_q.frame_byte_valid,
                        result_q.raw_restart};
   assign rsp_tlast  = result_q.frame_done;

`ifndef NO_ASSERTIONS
   // completion always carries a decoded byte
   a_done_has_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tuser[USER_VALID])
      else $error("frame completion without decoded byte");

   // completed length is one past the last index
   a_done_length: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> (result_q.frame_length == result_q.frame_index + 8'd1))
      else $error("frame length does not match final index");

   // start flag restarts the raw count
   a_restart_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[USER_RESTART] |-> (result_q.raw_length == 9'd1))
      else $error("raw count not restarted on start flag");

   // a stalled response keeps the input register from moving
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      out_valid && !rsp_tready |-> !advance)
      else $error("byte advanced into a stalled response register");
`endif

endmodule

// File: hw/rtl/stfr_tracker.sv
// ----------------------------------------------------------------------------
// stfr_tracker
// frame tracking state and per-byte unstuffing / completion decode
// ----------------------------------------------------------------------------
module stfr_tracker
   import stfr_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            advance,
   input  logic [7:0]      rx_byte,
   input  logic [7:0]      inject_threshold,
   output stfr_result_type result
);

   logic       start_pending_ff, start_pending_in;
   logic       escape_pending_ff, escape_pending_in;
   logic [7:0] frame_count_ff, frame_count_in;
   logic [7:0] frame_total_ff, frame_total_in;
   logic [7:0] dest_byte_ff, dest_byte_in;
   logic [8:0] raw_count_ff, raw_count_in;

   logic       is_start;
   logic       have;
   logic [7:0] dec_byte;
   logic [8:0] count_next;

   assign is_start   = (rx_byte == FLAG_START);
   assign count_next = {1'b0, frame_count_ff} + 9'd1;

   always_comb begin
      start_pending_in  = start_pending_ff;
      escape_pending_in = escape_pending_ff;
      frame_count_in    = frame_count_ff;
      frame_total_in    = frame_total_ff;
      dest_byte_in      = dest_byte_ff;
      raw_count_in      = raw_count_ff;
      have              = 1'b0;
      dec_byte          = rx_byte;
      result            = '0;

      // unstuffing and raw count
      if (is_start) begin
         raw_count_in      = 9'd1;
         start_pending_in  = 1'b1;
         escape_pending_in = 1'b0;
         frame_count_in    = 8'd0;
      end else begin
         if (raw_count_ff < RAW_MAX) begin
            raw_count_in = raw_count_ff + 9'd1;
         end
         if (escape_pending_ff) begin
            escape_pending_in = 1'b0;
            have              = (rx_byte == ESC_OF_7D) || (rx_byte == ESC_OF_7E);
            dec_byte          = (rx_byte == ESC_OF_7D) ? FLAG_ESCAPE : FLAG_START;
         end else if (rx_byte == FLAG_ESCAPE) begin
            escape_pending_in = 1'b1;
         end else begin
            have = 1'b1;
         end
      end

      // frame position
      if (have) begin
         priority if (start_pending_ff) begin
            start_pending_in        = 1'b0;
            dest_byte_in            = dec_byte;
            frame_count_in          = 8'd1;
            result.frame_byte_valid = 1'b1;
            result.frame_byte       = dec_byte;
         end else if (frame_count_ff == 8'd1) begin
            frame_total_in          = dec_byte + TOTAL_EXTRA;
            frame_count_in          = 8'd2;
            result.frame_byte_valid = 1'b1;
            result.frame_byte       = dec_byte;
            result.frame_index      = 8'd1;
         end else if (frame_count_ff > 8'd1) begin
            if (count_next <= {1'b0, frame_total_ff}) begin
               frame_count_in          = count_next[7:0];
               result.frame_byte_valid = 1'b1;
               result.frame_byte       = dec_byte;
               result.frame_index      = frame_count_ff;
               if (count_next == {1'b0, frame_total_ff}) begin
                  result.frame_done   = 1'b1;
                  result.frame_length = count_next[7:0];
                  result.route_inject = (dest_byte_ff >= inject_threshold);
               end
            end
         end else begin
            // no frame open: byte ignored
         end
      end

      result.raw_byte    = rx_byte;
      result.raw_restart = is_start;
      result.raw_length  = raw_count_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_pending_ff  <= 1'b0;
         escape_pending_ff <= 1'b0;
         frame_count_ff    <= '0;
         frame_total_ff    <= '0;
         dest_byte_ff      <= '0;
         raw_count_ff      <= '0;
      end else if (advance) begin
         start_pending_ff  <= start_pending_in;
         escape_pending_ff <= escape_pending_in;
         frame_count_ff    <= frame_count_in;
         frame_total_ff    <= frame_total_in;
         dest_byte_ff      <= dest_byte_in;
         raw_count_ff      <= raw_count_in;
      end
   end

endmodule

// File: hw/rtl/stfr_out_reg.sv
// ----------------------------------------------------------------------------
// stfr_out_reg
// response register with valid flag
// ----------------------------------------------------------------------------
module stfr_out_reg
   import stfr_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            load,
   input  stfr_result_type result_in,
   input  logic            take,
   output logic            valid,
   output stfr_result_type result_out
);

   logic            valid_ff, valid_in;
   stfr_result_type result_ff;

   assign valid_in = load | (valid_ff & ~take);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= result_in;
      end
   end

   assign valid      = valid_ff;
   assign result_out = result_ff;

endmodule
